/* rtl/core/rpb_pkg.sv */
// Shared types, widths and helpers for the relative position bucket core.
// Used by the log cell, the divide cell and the top level.
`default_nettype none

package rpb_pkg;

  localparam int unsigned PosBits     = 16;
  localparam int unsigned LogFracBits = 16;
  localparam int unsigned MaxBuckets  = 256;
  localparam int unsigned LogIntBits  = 4;
  localparam int unsigned LogW        = LogIntBits + LogFracBits;
  localparam int unsigned NumW        = LogW + 8;
  localparam int unsigned QuotBits    = 8;
  localparam int unsigned NumLanes    = 3;

  // Configuration register indexes.
  localparam logic [1:0] RegBucketCount   = 2'd0;
  localparam logic [1:0] RegDistanceLimit = 2'd1;
  localparam logic [1:0] RegTwoSided      = 2'd2;

  // Lanes of the log chain.
  localparam int unsigned LaneDist  = 0;
  localparam int unsigned LaneExact = 1;
  localparam int unsigned LaneLimit = 2;

  typedef struct packed {
    logic       fault;
    logic       exact;
    logic [8:0] ret;
    logic [8:0] n;
    logic [7:0] e;
  } rpb_ctrl_t;

  typedef struct packed {
    logic [31:0]     y;
    logic [LogW-1:0] acc;
  } rpb_lane_t;

  typedef rpb_lane_t [NumLanes-1:0] rpb_lanes_t;

  typedef struct packed {
    rpb_ctrl_t ctrl;
    logic      sat;
    logic      zspan;
  } rpb_dctrl_t;

  typedef struct packed {
    logic [NumW-1:0]     rem;
    logic [NumW-1:0]     den;
    logic [QuotBits-1:0] q;
  } rpb_div_t;

  // Integer part and normalized Q1.31 mantissa of a nonzero value.
  function automatic rpb_lane_t rpb_norm(input logic [PosBits-1:0] x);
    rpb_lane_t            r;
    logic [LogIntBits-1:0] k;
    k = '0;
    for (int i = 1; i < PosBits; i++) begin
      if (x[i]) begin
        k = LogIntBits'(i);
      end
    end
    r.y   = {{(32-PosBits){1'b0}}, x} << (5'd31 - 5'(k));
    r.acc = LogW'(k);
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/rpb_log_cell.sv */
// One squaring step of the fixed-point log2 chain, for all lanes of a request.
// Depends on rpb_pkg.
`default_nettype none

module rpb_log_cell
  import rpb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  rpb_ctrl_t  ctrl_i,
  input  rpb_lanes_t lanes_i,
  output logic       valid_o,
  output rpb_ctrl_t  ctrl_o,
  output rpb_lanes_t lanes_o
);

  logic       valid_q;
  rpb_ctrl_t  ctrl_q;
  rpb_lanes_t lanes_q, lanes_d;

  always_comb begin
    logic [63:0] sq;
    logic [32:0] t;
    lanes_d = lanes_i;
    for (int l = 0; l < NumLanes; l++) begin
      sq = 64'(lanes_i[l].y) * 64'(lanes_i[l].y);
      t  = sq[63:31];
      // A square at or above two yields a one bit and is halved.
      lanes_d[l].y   = t[32] ? t[32:1] : t[31:0];
      lanes_d[l].acc = {lanes_i[l].acc[LogW-2:0], t[32]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctrl_q  <= ctrl_i;
      lanes_q <= lanes_d;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign lanes_o = lanes_q;

endmodule

`default_nettype wire

/* rtl/core/rpb_div_cell.sv */
// One restoring quotient bit of the log ratio divide.
// Depends on rpb_pkg.
`default_nettype none

module rpb_div_cell
  import rpb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  rpb_dctrl_t ctrl_i,
  input  rpb_div_t   div_i,
  output logic       valid_o,
  output rpb_dctrl_t ctrl_o,
  output rpb_div_t   div_o
);

  logic       valid_q;
  rpb_dctrl_t ctrl_q;
  rpb_div_t   div_q, div_d;

  always_comb begin
    logic ge;
    ge = div_i.rem >= div_i.den;
    div_d.rem = ge ? div_i.rem - div_i.den : div_i.rem;
    div_d.den = div_i.den >> 1;
    div_d.q   = {div_i.q[QuotBits-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctrl_q <= ctrl_i;
      div_q  <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign div_o   = div_q;

endmodule

`default_nettype wire

/* rtl/core/relative_position_bucket_core.sv */
// Top level of the relative position bucket core: setup registers, input
// decode, log2 cell chain, divide cell chain and output register.
// Depends on rpb_pkg, rpb_log_cell and rpb_div_cell.
//
// Usage:
//   A request carries one signed relative position on rel_pos_i, qualified
//   by in_valid_i and taken at an edge where in_stall_o is low. The result
//   (bucket_o, setup_fault_o) is shown with out_valid_o and is taken at an
//   edge where out_stall_i is low.
//   Setup registers are written through cfg_we_i, cfg_idx_i and cfg_data_i
//   while no request is in flight.
//   From acceptance to out_valid_o a request passes one decode stage,
//   sixteen log2 squaring cells, two divide setup stages, eight quotient
//   cells and the output register. One request is accepted every cycle
//   while in_stall_o is low; the cell chains advance together.
//   When the receiver stalls with a result waiting, the whole chain holds
//   and in_stall_o goes high in the same cycle. Reset empties the chain and
//   loads the setup registers with 32 buckets, limit 128 and two-sided mode.
`default_nettype none

module relative_position_bucket_core
  import rpb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [15:0]  rel_pos_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          bucket_o,
  output logic                setup_fault_o
);

  localparam int unsigned LogCells = LogFracBits;

  logic        en;
  logic [8:0]  bucket_count_q;
  logic [15:0] distance_limit_q;
  logic        two_sided_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q   <= 9'd32;
      distance_limit_q <= 16'd128;
      two_sided_q      <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegBucketCount:   bucket_count_q   <= cfg_data_i[8:0];
        RegDistanceLimit: distance_limit_q <= cfg_data_i;
        RegTwoSided:      two_sided_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic out_valid_q;
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // Decode stage.
  rpb_ctrl_t  ctrl_d;
  rpb_lanes_t lanes_d;

  always_comb begin
    logic        neg;
    logic [15:0] mag, d;
    logic [8:0]  n;
    logic [7:0]  e;
    neg = rel_pos_i[PosBits-1];
    mag = neg ? 16'(-rel_pos_i) : rel_pos_i;
    n   = two_sided_q ? {1'b0, bucket_count_q[8:1]} : bucket_count_q;
    e   = n[8:1];
    ctrl_d.n     = n;
    ctrl_d.e     = e;
    ctrl_d.fault = bucket_count_q[0] || (bucket_count_q > 9'(MaxBuckets)) ||
                   (e == 8'd0) || (distance_limit_q <= 16'(e));
    d = two_sided_q ? mag : (neg ? mag : 16'd0);
    ctrl_d.exact = d < 16'(e);
    // An exact distance is folded into the base, so the log path adds nothing for it.
    ctrl_d.ret   = ((two_sided_q && !neg && rel_pos_i != '0) ? n : 9'd0) +
                   (ctrl_d.exact ? 9'(d) : 9'd0);
    lanes_d[LaneDist]  = rpb_norm(d);
    lanes_d[LaneExact] = rpb_norm(16'(e));
    lanes_d[LaneLimit] = rpb_norm(distance_limit_q);
  end

  logic       lv    [0:LogCells];
  rpb_ctrl_t  lc    [0:LogCells];
  rpb_lanes_t lanes [0:LogCells];
  logic       s0_valid_q;
  rpb_ctrl_t  s0_ctrl_q;
  rpb_lanes_t s0_lanes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_ctrl_q  <= ctrl_d;
      s0_lanes_q <= lanes_d;
    end
  end

  assign lv[0]    = s0_valid_q;
  assign lc[0]    = s0_ctrl_q;
  assign lanes[0] = s0_lanes_q;

  for (genvar g = 0; g < LogCells; g++) begin : g_log
    rpb_log_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (lv[g]),
      .ctrl_i  (lc[g]),
      .lanes_i (lanes[g]),
      .valid_o (lv[g+1]),
      .ctrl_o  (lc[g+1]),
      .lanes_o (lanes[g+1])
    );
  end

  // Log differences and the scaled numerator.
  logic            d0_valid_q;
  rpb_ctrl_t       d0_ctrl_q;
  logic            d0_zspan_q;
  logic [NumW-1:0] d0_num_q;
  logic [LogW-1:0] d0_span_q;
  logic [NumW-1:0] d0_num_d;
  logic [LogW-1:0] d0_span_d;
  logic            d0_zspan_d;

  always_comb begin
    logic [LogW-1:0] ld, le, ll, a;
    logic [7:0]      m;
    ld = lanes[LogCells][LaneDist].acc;
    le = lanes[LogCells][LaneExact].acc;
    ll = lanes[LogCells][LaneLimit].acc;
    a  = (ld > le) ? ld - le : '0;
    m  = 8'(lc[LogCells].n - 9'(lc[LogCells].e));
    d0_num_d  = NumW'(a) * NumW'(m);
    d0_span_d = ll - le;
    d0_zspan_d = ll <= le;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d0_valid_q <= 1'b0;
    end else if (en) begin
      d0_valid_q <= lv[LogCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d0_ctrl_q  <= lc[LogCells];
      d0_zspan_q <= d0_zspan_d;
      d0_num_q   <= d0_num_d;
      d0_span_q  <= d0_span_d;
    end
  end

  // Saturation check: a quotient of 256 or more always clamps.
  logic       dv  [0:QuotBits];
  rpb_dctrl_t dc  [0:QuotBits];
  rpb_div_t   dd  [0:QuotBits];
  logic       d1_valid_q;
  rpb_dctrl_t d1_ctrl_q;
  rpb_div_t   d1_div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_valid_q <= 1'b0;
    end else if (en) begin
      d1_valid_q <= d0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_ctrl_q.ctrl  <= d0_ctrl_q;
      d1_ctrl_q.zspan <= d0_zspan_q;
      d1_ctrl_q.sat   <= d0_num_q >= (NumW'(d0_span_q) << QuotBits);
      d1_div_q.rem    <= d0_num_q;
      d1_div_q.den    <= NumW'(d0_span_q) << (QuotBits - 1);
      d1_div_q.q      <= '0;
    end
  end

  assign dv[0] = d1_valid_q;
  assign dc[0] = d1_ctrl_q;
  assign dd[0] = d1_div_q;

  for (genvar g = 0; g < QuotBits; g++) begin : g_div
    rpb_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[g]),
      .ctrl_i  (dc[g]),
      .div_i   (dd[g]),
      .valid_o (dv[g+1]),
      .ctrl_o  (dc[g+1]),
      .div_o   (dd[g+1])
    );
  end

  // Final assembly.
  logic [7:0] bucket_d, bucket_q;
  logic       fault_q;

  always_comb begin
    rpb_dctrl_t c;
    logic [8:0] last, far_bucket, sum, qe;
    c     = dc[QuotBits];
    last  = c.ctrl.n - 9'd1;
    qe    = 9'(c.ctrl.e) + 9'(dd[QuotBits].q);
    if (c.ctrl.exact) begin
      far_bucket = 9'd0;
    end else if (c.zspan || c.sat || qe > last) begin
      far_bucket = last;
    end else begin
      far_bucket = qe;
    end
    sum = c.ctrl.ret + far_bucket;
    bucket_d = c.ctrl.fault ? 8'd0 : sum[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv[QuotBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bucket_q <= bucket_d;
      fault_q  <= dc[QuotBits].ctrl.fault;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign bucket_o      = bucket_q;
  assign setup_fault_o = fault_q;

endmodule

`default_nettype wire
